@@ hdl/shs_pkg.sv @@
`default_nettype none
package shs_pkg;

    typedef logic [31:0] word_t;

    localparam int NUM_ROUNDS = 80;
    localparam int SCHED_DEPTH = 16;

    // round constants
    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    // initial chaining words, index 0 is H0
    localparam word_t [4:0] H_INIT = '{
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // padding
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } shs_state_t;

    // control towards the round unit
    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic init;
    } shs_round_ctrl_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ hdl/shs_in_if.sv @@
`default_nettype none
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (
        output valid, msg_byte, byte_valid, end_of_message,
        input  ready
    );
    modport sink (
        input  valid, msg_byte, byte_valid, end_of_message,
        output ready
    );
endinterface
`default_nettype wire

@@ hdl/shs_out_if.sv @@
`default_nettype none
interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_high;
    logic [63:0] digest_middle;
    logic [31:0] digest_low;

    modport source (
        output valid, digest_high, digest_middle, digest_low,
        input  ready
    );
    modport sink (
        input  valid, digest_high, digest_middle, digest_low,
        output ready
    );
endinterface
`default_nettype wire

@@ hdl/shs_word_cell.sv @@
`default_nettype none
module shs_word_cell
    import shs_pkg::*;
(
    input  wire   clk,
    input  wire   shift,
    input  word_t d,
    output word_t q
);

    word_t q_reg;

    // take the neighbour's word on every shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

@@ hdl/shs_round_unit.sv @@
`default_nettype none
module shs_round_unit
    import shs_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  shs_round_ctrl_t ctrl,
    input  logic [6:0]      round_idx,
    input  word_t           w,
    output word_t [4:0]     h
);

    word_t [4:0] h_reg;
    word_t [4:0] work_reg;
    word_t       f;
    word_t       k;
    word_t       t;

    // round function and constant by round group
    always_comb
    begin
        priority if (round_idx < 7'd20)
        begin
            f = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k = K_0;
        end
        else if (round_idx < 7'd40)
        begin
            f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k = K_1;
        end
        else if (round_idx < 7'd60)
        begin
            f = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
              | (work_reg[2] & work_reg[3]);
            k = K_2;
        end
        else
        begin
            f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k = K_3;
        end
        t = rotl(work_reg[0], 5) + f + work_reg[4] + k + w;
    end

    // working words a..e
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            work_reg <= h_reg;
        end
        else if (ctrl.step)
        begin
            work_reg[0] <= t;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= rotl(work_reg[1], 30);
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    // chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= H_INIT;
        end
        else if (ctrl.init)
        begin
            h_reg <= H_INIT;
        end
        else if (ctrl.add)
        begin
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= h_reg[i] + work_reg[i];
            end
        end
    end

    assign h = h_reg;

endmodule
`default_nettype wire

@@ hdl/sha1_stream_hash_core.sv @@
`default_nettype none
// channel   dir   payload                                            handshake
// in_ch     in    msg_byte[8], byte_valid, end_of_message           valid/ready
// out_ch    out   digest_high[64], digest_middle[64], digest_low[32] valid/ready
//
// one byte is taken per cycle while ready; every 64th byte (message or
// padding) starts the 80-round compression, one round per cycle through the
// 16-cell schedule chain, then the chaining add; input stalls meanwhile.
// an end mark inserts padding at one byte per cycle outside the rounds (9 to
// 72 bytes and one or two compressions), then the ST_OUT state loads the
// digest into the output register once that register is free. rst_n clears
// control and bit count and sets the initial chaining words at once; buffer
// cells are not reset. the digest register holds while out_ch stalls; input
// keeps flowing until a further digest would overwrite an untaken one.
module sha1_stream_hash_core
    import shs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    shs_in_if.sink     in_ch,
    shs_out_if.source  out_ch
);

    shs_state_t      state_reg;
    shs_state_t      state_next;
    shs_round_ctrl_t rctrl;

    logic [63:0] bit_count_reg;
    logic [63:0] len_reg;
    logic [5:0]  pos_reg;
    logic [23:0] acc_reg;
    logic [6:0]  round_reg;
    logic        pad_active_reg;
    logic        sent80_reg;
    logic        len_phase_reg;
    logic        final_reg;
    logic        out_valid_reg;
    logic [63:0] dig_high_reg;
    logic [63:0] dig_mid_reg;
    logic [31:0] dig_low_reg;

    logic        accept;
    logic        in_ready;
    logic        feed_en;
    logic [7:0]  feed_byte;
    logic        push;
    logic        block_full;
    logic        len_ph;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    logic        digest_load;
    logic        out_free;
    logic        round_last;
    logic        sched_shift;
    word_t       w_new;
    word_t       chain_in;
    word_t [SCHED_DEPTH-1:0] cell_q;
    word_t [4:0] h;

    assign accept     = in_ch.valid && in_ready;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign round_last = (round_reg == 7'(NUM_ROUNDS - 1));

    // padding byte source
    assign len_ph   = sent80_reg && (len_phase_reg || pos_reg == LEN_POS);
    assign len_byte = 8'(len_reg >> {~pos_reg[2:0], 3'b000});
    always_comb
    begin
        priority if (!sent80_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_ph)
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (block_full)
                begin
                    state_next = ST_ROUND;
                end
                else if (accept && in_ch.end_of_message)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                priority if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready    = 1'b0;
        feed_en     = 1'b0;
        feed_byte   = in_ch.msg_byte;
        rctrl       = '0;
        digest_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                feed_en  = in_ch.valid && in_ch.byte_valid;
            end
            ST_PAD:
            begin
                feed_en   = 1'b1;
                feed_byte = pad_byte;
            end
            ST_ROUND:
            begin
                rctrl.step = 1'b1;
            end
            ST_ADD:
            begin
                rctrl.add = 1'b1;
            end
            ST_OUT:
            begin
                digest_load = out_free;
                rctrl.init  = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        push       = feed_en && (pos_reg[1:0] == 2'b11);
        block_full = feed_en && (pos_reg == LAST_POS);
        rctrl.load = block_full;
    end

    assign in_ch.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // message length and block position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (accept && in_ch.end_of_message)
            begin
                bit_count_reg <= '0;
            end
            else if (accept && in_ch.byte_valid)
            begin
                bit_count_reg <= bit_count_reg + 64'd8;
            end
            if (feed_en)
            begin
                pos_reg <= pos_reg + 6'd1;
            end
        end
    end

    // length latched at the end mark
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.end_of_message)
        begin
            len_reg <= in_ch.byte_valid ? bit_count_reg + 64'd8 : bit_count_reg;
        end
    end

    // padding progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_active_reg <= 1'b0;
            sent80_reg     <= 1'b0;
            len_phase_reg  <= 1'b0;
            final_reg      <= 1'b0;
        end
        else if (digest_load)
        begin
            pad_active_reg <= 1'b0;
            sent80_reg     <= 1'b0;
            len_phase_reg  <= 1'b0;
            final_reg      <= 1'b0;
        end
        else
        begin
            if (accept && in_ch.end_of_message)
            begin
                pad_active_reg <= 1'b1;
            end
            if (state_reg == ST_PAD)
            begin
                sent80_reg <= 1'b1;
                if (len_ph)
                begin
                    len_phase_reg <= 1'b1;
                end
                if (len_ph && block_full)
                begin
                    final_reg <= 1'b1;
                end
            end
        end
    end

    // byte to word packing
    always_ff @(posedge clk)
    begin
        if (feed_en)
        begin
            acc_reg <= {acc_reg[15:0], feed_byte};
        end
    end

    // round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
        end
        else if (rctrl.load)
        begin
            round_reg <= '0;
        end
        else if (rctrl.step)
        begin
            round_reg <= round_reg + 7'd1;
        end
    end

    // schedule chain: cell 0 holds w[t], new words enter at the far end
    assign w_new       = rotl(cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0], 1);
    assign chain_in    = (state_reg == ST_ROUND) ? w_new : {acc_reg, feed_byte};
    assign sched_shift = push || rctrl.step;

    for (genvar i = 0; i < SCHED_DEPTH; i++)
    begin : g_cell
        shs_word_cell u_cell (
            .clk   (clk),
            .shift (sched_shift),
            .d     ((i == SCHED_DEPTH - 1) ? chain_in : cell_q[(i + 1) % SCHED_DEPTH]),
            .q     (cell_q[i])
        );
    end

    shs_round_unit u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rctrl),
        .round_idx (round_reg),
        .w         (cell_q[0]),
        .h         (h)
    );

    // digest output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (digest_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digest_load)
        begin
            dig_high_reg <= {h[0], h[1]};
            dig_mid_reg  <= {h[2], h[3]};
            dig_low_reg  <= h[4];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.digest_high   = dig_high_reg;
    assign out_ch.digest_middle = dig_mid_reg;
    assign out_ch.digest_low    = dig_low_reg;

endmodule
`default_nettype wire
